### src/ldar_pkg.sv
package ldar_pkg;

  localparam int unsigned MaxOrderDef = 32;

  localparam logic signed [31:0] VMax = 32'sh7fffffff;
  localparam logic signed [31:0] VMin = 32'sh80000000;
  localparam logic signed [49:0] OneQ24 = 50'sd16777216;

  typedef enum logic [1:0] {
    CFG_ORDER_MAX = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_SAMPLES   = 2'd2,
    CFG_UNUSED    = 2'd3
  } ldar_cfg_e;

  typedef enum logic [5:0] {
    S_LOAD, S_I0, S_I1, S_I2, S_C1W, S_C1M1, S_C1M2, S_C1M3, S_C1M4, S_C1M5,
    S_AK, S_AKW, S_PR0, S_PR1, S_PR2, S_PR3, S_PR4, S_OD0, S_OD1, S_OD2,
    S_V0, S_V1, S_V2, S_CW, S_CO0, S_CO1, S_CO2, S_CL, S_CL1, S_CL2, S_CL3,
    S_DQ0, S_DQ1, S_DQ2, S_DQ3, S_DQ4, S_FIN, S_SC1, S_SCW, S_ORD, S_OWR
  } ldar_state_e;

  function automatic logic signed [49:0] sx32(input logic signed [31:0] x);
    return {{18{x[31]}}, x};
  endfunction

  function automatic logic signed [49:0] sx42(input logic signed [41:0] x);
    return {{8{x[41]}}, x};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > sx32(VMax)) begin
      return VMax;
    end else if (x < sx32(VMin)) begin
      return VMin;
    end
    return x[31:0];
  endfunction

endpackage

### src/levinson_durbin_ar_fit.sv
// Levinson-Durbin autoregressive fit; load takes one lag request per cycle.
// The request for the highest lag in use starts the fit; input stalls until the last result.
// Fit per order l: two divisions plus predictor, coefficient and dot-product updates; the
//   bit-serial divider and the single shared multiplier set the fit time.
// Results: variance scaled by n/(n-order-1) or flagged, then coefficients in index order.
// Reset (rst_ni low, async): control registers to defaults, sequencer idles in load.
module levinson_durbin_ar_fit import ldar_pkg::*; #(
  parameter int unsigned ORDER_CAP = MaxOrderDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [5:0]         lag_index_i,
  input  logic signed [31:0] r_value_i,
  input  logic signed [31:0] g_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] coef_value_o,
  output logic [4:0]         coef_index_o,
  output logic [5:0]         order_found_o,
  output logic signed [31:0] noise_variance_o,
  output logic               scale_error_o,
  output logic               last_result_o
);

  // lag/order counter width and coefficient index width
  localparam int unsigned LW = $clog2(ORDER_CAP + 1);
  localparam int unsigned CW = (ORDER_CAP > 1) ? $clog2(ORDER_CAP) : 1;

  // configuration registers
  logic [5:0]  ord_max_q;
  logic [24:0] thr_q;
  logic [31:0] n_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ord_max_q <= 6'd1;
      thr_q     <= 25'd167772;
      n_q       <= 32'd1000;
    end else if (cfg_valid_i) begin
      case (ldar_cfg_e'(cfg_index_i))
        CFG_ORDER_MAX: ord_max_q <= cfg_data_i[5:0];
        CFG_THRESHOLD: thr_q     <= cfg_data_i[24:0];
        CFG_SAMPLES:   n_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective order: zero acts as one, above the store depth clamps
  logic [LW-1:0] om_eff;
  always_comb begin
    if (ord_max_q == 6'd0) begin
      om_eff = LW'(1);
    end else if (7'(ord_max_q) > 7'(ORDER_CAP)) begin
      om_eff = LW'(ORDER_CAP);
    end else begin
      om_eff = LW'(ord_max_q);
    end
  end

  // memories: lag stores, predictor work vector, coefficient row
  logic signed [31:0] ac_mem  [ORDER_CAP+1];
  logic signed [31:0] rhs_mem [ORDER_CAP+1];
  logic signed [31:0] pw_mem  [ORDER_CAP];
  logic signed [31:0] cf_mem  [ORDER_CAP];

  logic               ac_we, pw_we, cf_we;
  logic [LW-1:0]      ac_waddr, ac_raddr, rhs_raddr;
  logic [CW-1:0]      pw_waddr, pw_raddr, cf_waddr, cf_raddr;
  logic signed [31:0] pw_wdata, cf_wdata;
  logic signed [31:0] ac_rd, rhs_rd, pw_rd, cf_rd;

  always_ff @(posedge clk_i) begin
    if (ac_we) begin
      ac_mem[ac_waddr]  <= r_value_i;
      rhs_mem[ac_waddr] <= g_value_i;
    end
    ac_rd  <= ac_mem[ac_raddr];
    rhs_rd <= rhs_mem[rhs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pw_we) begin
      pw_mem[pw_waddr] <= pw_wdata;
    end
    pw_rd <= pw_mem[pw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cf_we) begin
      cf_mem[cf_waddr] <= cf_wdata;
    end
    cf_rd <= cf_mem[cf_raddr];
  end

  // shared multiplier, product registered
  logic signed [32:0] ma, mb;
  logic signed [65:0] raw_q;
  logic signed [65:0] rnd_full;
  logic signed [41:0] rnd;

  always_ff @(posedge clk_i) begin
    raw_q <= ma * mb;
  end

  // round half up, drop 24 fraction bits
  assign rnd_full = (raw_q + 66'sd8388608) >>> 24;
  assign rnd      = rnd_full[41:0];

  // radix-2 restoring divider, truncates toward zero
  logic               dv_start;
  logic signed [63:0] dv_num;
  logic signed [33:0] dv_den;
  logic               dv_busy_q;
  logic [6:0]         dv_cnt_q;
  logic [63:0]        dv_nm_q, dv_quo_q;
  logic [32:0]        dv_rem_q, dv_dm_q;
  logic               dv_neg_q, dv_zero_q, dv_nneg_q;
  logic               dv_done;
  logic signed [31:0] dv_res;
  logic [33:0]        dv_rs;
  logic [34:0]        dv_ds;

  assign dv_rs   = {dv_rem_q, dv_nm_q[63]};
  assign dv_ds   = {1'b0, dv_rs} - {2'b00, dv_dm_q};
  assign dv_done = dv_busy_q && (dv_cnt_q == 7'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_cnt_q  <= 7'd0;
    end else if (dv_start) begin
      dv_busy_q <= 1'b1;
      dv_cnt_q  <= (dv_den == 34'sd0) ? 7'd0 : 7'd64;
    end else if (dv_busy_q) begin
      if (dv_cnt_q != 7'd0) begin
        dv_cnt_q <= dv_cnt_q - 7'd1;
      end else begin
        dv_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_start) begin
      dv_nm_q   <= dv_num[63] ? 64'(-dv_num) : 64'(dv_num);
      dv_dm_q   <= dv_den[33] ? 33'(-dv_den) : 33'(dv_den);
      dv_rem_q  <= '0;
      dv_quo_q  <= '0;
      dv_neg_q  <= dv_num[63] ^ dv_den[33];
      dv_zero_q <= (dv_den == 34'sd0);
      dv_nneg_q <= !dv_num[63];
    end else if (dv_busy_q && (dv_cnt_q != 7'd0)) begin
      dv_nm_q <= {dv_nm_q[62:0], 1'b0};
      if (!dv_ds[34]) begin
        dv_rem_q <= dv_ds[32:0];
        dv_quo_q <= {dv_quo_q[62:0], 1'b1};
      end else begin
        dv_rem_q <= dv_rs[32:0];
        dv_quo_q <= {dv_quo_q[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (dv_zero_q) begin
      dv_res = dv_nneg_q ? VMax : VMin;
    end else if (dv_neg_q) begin
      dv_res = (dv_quo_q > 64'h80000000) ? VMin : 32'(32'd0 - dv_quo_q[31:0]);
    end else begin
      dv_res = (dv_quo_q > 64'h7fffffff) ? VMax : dv_quo_q[31:0];
    end
  end

  // sequencer state
  ldar_state_e        state_q, state_d;
  logic [LW-1:0]      om_q, om_d, l_q, l_d, j_q, j_d, k_q, k_d, ord_q, ord_d;
  logic signed [31:0] ac0_q, ac0_d, r1_q, r1_d, v_q, v_d, cross_q, cross_d;
  logic signed [31:0] psum_q, psum_d, rvar_q, rvar_d, c_q, c_d, ak_q, ak_d;
  logic signed [31:0] hold_q, hold_d, pk_q, pk_d, t_q, t_d, var_q, var_d;
  logic signed [47:0] sumd_q, sumd_d, sumq_q, sumq_d;
  logic               err_q, err_d;
  logic               ov_q, ov_d;
  logic signed [31:0] oc_q, oc_d, ovar_q, ovar_d;
  logic [4:0]         oi_q, oi_d;
  logic [5:0]         oo_q, oo_d;
  logic               oe_q, oe_d, ol_q, ol_d;

  logic               in_acc;
  logic [LW-1:0]      jm1, lmj, lm1, h2, lmi1;
  logic [32:0]        cmag;
  logic signed [32:0] diff33, neg33;
  logic signed [31:0] var_sel;
  logic [32:0]        need33;
  logic               out_free;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign jm1  = j_q - LW'(1);
  assign lmj  = l_q - j_q;
  assign lm1  = l_q - LW'(1);
  assign h2   = l_q >> 1;
  assign lmi1 = l_q - j_q + LW'(1);
  assign cmag = dv_res[31] ? 33'(-{dv_res[31], dv_res}) : {1'b0, dv_res};
  assign diff33 = {rhs_rd[31], rhs_rd} - {psum_q[31], psum_q};
  assign neg33  = -{cross_q[31], cross_q};
  assign var_sel = (ord_q != '0) ? rvar_q : ac0_q;
  assign need33  = 33'(ord_q) + 33'd1;
  assign out_free = !ov_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    om_d = om_q; l_d = l_q; j_d = j_q; k_d = k_q; ord_d = ord_q;
    ac0_d = ac0_q; r1_d = r1_q; v_d = v_q; cross_d = cross_q; psum_d = psum_q;
    rvar_d = rvar_q; c_d = c_q; ak_d = ak_q; hold_d = hold_q; pk_d = pk_q;
    t_d = t_q; var_d = var_q; sumd_d = sumd_q; sumq_d = sumq_q; err_d = err_q;
    ov_d = ov_q && out_stall_i;
    oc_d = oc_q; oi_d = oi_q; oo_d = oo_q; ovar_d = ovar_q; oe_d = oe_q; ol_d = ol_q;
    ac_we = 1'b0; ac_waddr = LW'(lag_index_i); ac_raddr = '0; rhs_raddr = '0;
    pw_we = 1'b0; pw_waddr = '0; pw_wdata = '0; pw_raddr = '0;
    cf_we = 1'b0; cf_waddr = '0; cf_wdata = '0; cf_raddr = '0;
    ma = '0; mb = '0;
    dv_start = 1'b0; dv_num = '0; dv_den = '0;

    case (state_q)
      S_LOAD: begin
        // store the lag; drop lags beyond the store
        if (in_acc && (7'(lag_index_i) <= 7'(ORDER_CAP))) begin
          ac_we = 1'b1;
          if (7'(lag_index_i) == 7'(om_eff)) begin
            om_d = om_eff;
            state_d = S_I0;
          end
        end
      end
      S_I0: begin
        ac_raddr = '0;
        state_d = S_I1;
      end
      S_I1: begin
        ac0_d = ac_rd;
        ac_raddr = LW'(1);
        rhs_raddr = LW'(1);
        state_d = S_I2;
      end
      S_I2: begin
        r1_d = ac_rd;
        cross_d = ac_rd;
        v_d = ac0_q;
        pw_we = 1'b1;
        pw_waddr = '0;
        pw_wdata = OneQ24[31:0];
        dv_start = 1'b1;
        dv_num = {{7{rhs_rd[31]}}, rhs_rd[31], rhs_rd, 24'd0};
        dv_den = {{2{ac0_q[31]}}, ac0_q};
        state_d = S_C1W;
      end
      S_C1W: begin
        if (dv_done) begin
          c_d = dv_res;
          if (cmag <= {8'd0, thr_q}) begin
            ord_d = '0;
            state_d = S_FIN;
          end else begin
            cf_we = 1'b1;
            cf_waddr = '0;
            cf_wdata = dv_res;
            state_d = S_C1M1;
          end
        end
      end
      S_C1M1: begin
        ma = {c_q[31], c_q};
        mb = {r1_q[31], r1_q};
        state_d = S_C1M2;
      end
      S_C1M2: begin
        psum_d = sat32(sx42(rnd));
        ma = {c_q[31], c_q};
        mb = {c_q[31], c_q};
        state_d = S_C1M3;
      end
      S_C1M3: begin
        t_d = sat32(OneQ24 - sx42(rnd));
        state_d = S_C1M4;
      end
      S_C1M4: begin
        ma = {t_q[31], t_q};
        mb = {ac0_q[31], ac0_q};
        state_d = S_C1M5;
      end
      S_C1M5: begin
        rvar_d = sat32(sx42(rnd));
        if (om_q == LW'(1)) begin
          ord_d = LW'(1);
          state_d = S_FIN;
        end else begin
          l_d = LW'(2);
          state_d = S_AK;
        end
      end
      S_AK: begin
        dv_start = 1'b1;
        dv_num = {{7{neg33[32]}}, neg33, 24'd0};
        dv_den = {{2{v_q[31]}}, v_q};
        state_d = S_AKW;
      end
      S_AKW: begin
        if (dv_done) begin
          ak_d = dv_res;
          pw_we = 1'b1;
          pw_waddr = lm1[CW-1:0];
          pw_wdata = dv_res;
          j_d = LW'(2);
          if (l_q >= LW'(4)) begin
            state_d = S_PR0;
          end else if (l_q == LW'(3)) begin
            state_d = S_OD0;
          end else begin
            state_d = S_V0;
          end
        end
      end
      S_PR0: begin
        pw_raddr = jm1[CW-1:0];
        state_d = S_PR1;
      end
      S_PR1: begin
        hold_d = pw_rd;
        pw_raddr = lmj[CW-1:0];
        state_d = S_PR2;
      end
      S_PR2: begin
        pk_d = pw_rd;
        ma = {ak_q[31], ak_q};
        mb = {pw_rd[31], pw_rd};
        state_d = S_PR3;
      end
      S_PR3: begin
        pw_we = 1'b1;
        pw_waddr = jm1[CW-1:0];
        pw_wdata = sat32(sx32(hold_q) + sx42(rnd));
        ma = {ak_q[31], ak_q};
        mb = {hold_q[31], hold_q};
        state_d = S_PR4;
      end
      S_PR4: begin
        pw_we = 1'b1;
        pw_waddr = lmj[CW-1:0];
        pw_wdata = sat32(sx32(pk_q) + sx42(rnd));
        if (j_q == h2) begin
          state_d = l_q[0] ? S_OD0 : S_V0;
        end else begin
          j_d = j_q + LW'(1);
          state_d = S_PR0;
        end
      end
      S_OD0: begin
        // middle term of an odd-length update
        t_d = sat32(OneQ24 + sx32(ak_q));
        pw_raddr = h2[CW-1:0];
        state_d = S_OD1;
      end
      S_OD1: begin
        ma = {pw_rd[31], pw_rd};
        mb = {t_q[31], t_q};
        state_d = S_OD2;
      end
      S_OD2: begin
        pw_we = 1'b1;
        pw_waddr = h2[CW-1:0];
        pw_wdata = sat32(sx42(rnd));
        state_d = S_V0;
      end
      S_V0: begin
        ma = {ak_q[31], ak_q};
        mb = {cross_q[31], cross_q};
        state_d = S_V1;
      end
      S_V1: begin
        v_d = sat32(sx32(v_q) + sx42(rnd));
        rhs_raddr = l_q;
        state_d = S_V2;
      end
      S_V2: begin
        dv_start = 1'b1;
        dv_num = {{7{diff33[32]}}, diff33, 24'd0};
        dv_den = {{2{v_q[31]}}, v_q};
        state_d = S_CW;
      end
      S_CW: begin
        if (dv_done) begin
          c_d = dv_res;
          if (cmag <= {8'd0, thr_q}) begin
            ord_d = lm1;
            state_d = S_FIN;
          end else begin
            j_d = LW'(1);
            state_d = S_CO0;
          end
        end
      end
      S_CO0: begin
        cf_raddr = jm1[CW-1:0];
        pw_raddr = lmj[CW-1:0];
        state_d = S_CO1;
      end
      S_CO1: begin
        hold_d = cf_rd;
        ma = {c_q[31], c_q};
        mb = {pw_rd[31], pw_rd};
        state_d = S_CO2;
      end
      S_CO2: begin
        cf_we = 1'b1;
        cf_waddr = jm1[CW-1:0];
        cf_wdata = sat32(sx32(hold_q) + sx42(rnd));
        if (j_q == lm1) begin
          state_d = S_CL;
        end else begin
          j_d = j_q + LW'(1);
          state_d = S_CO0;
        end
      end
      S_CL: begin
        cf_we = 1'b1;
        cf_waddr = lm1[CW-1:0];
        cf_wdata = c_q;
        ma = {c_q[31], c_q};
        mb = {c_q[31], c_q};
        state_d = S_CL1;
      end
      S_CL1: begin
        t_d = sat32(OneQ24 - sx42(rnd));
        state_d = S_CL2;
      end
      S_CL2: begin
        ma = {rvar_q[31], rvar_q};
        mb = {t_q[31], t_q};
        state_d = S_CL3;
      end
      S_CL3: begin
        rvar_d = sat32(sx42(rnd));
        if (l_q == om_q) begin
          ord_d = om_q;
          state_d = S_FIN;
        end else begin
          j_d = LW'(1);
          sumd_d = '0;
          sumq_d = '0;
          state_d = S_DQ0;
        end
      end
      S_DQ0: begin
        // j walks the dot products over the new order
        pw_raddr = jm1[CW-1:0];
        cf_raddr = jm1[CW-1:0];
        ac_raddr = lmi1;
        state_d = S_DQ1;
      end
      S_DQ1: begin
        hold_d = cf_rd;
        pk_d = ac_rd;
        ma = {pw_rd[31], pw_rd};
        mb = {ac_rd[31], ac_rd};
        state_d = S_DQ2;
      end
      S_DQ2: begin
        sumd_d = sumd_q + {{6{rnd[41]}}, rnd};
        ma = {hold_q[31], hold_q};
        mb = {pk_q[31], pk_q};
        state_d = S_DQ3;
      end
      S_DQ3: begin
        sumq_d = sumq_q + {{6{rnd[41]}}, rnd};
        if (j_q == l_q) begin
          state_d = S_DQ4;
        end else begin
          j_d = j_q + LW'(1);
          state_d = S_DQ0;
        end
      end
      S_DQ4: begin
        cross_d = sat32({{2{sumd_q[47]}}, sumd_q});
        psum_d = sat32({{2{sumq_q[47]}}, sumq_q});
        l_d = l_q + LW'(1);
        state_d = S_AK;
      end
      S_FIN: begin
        k_d = '0;
        if ({1'b0, n_q} <= need33) begin
          err_d = 1'b1;
          var_d = '0;
          state_d = S_ORD;
        end else begin
          err_d = 1'b0;
          ma = {var_sel[31], var_sel};
          mb = {1'b0, n_q};
          state_d = S_SC1;
        end
      end
      S_SC1: begin
        dv_start = 1'b1;
        dv_num = raw_q[63:0];
        dv_den = {1'b0, {1'b0, n_q} - need33};
        state_d = S_SCW;
      end
      S_SCW: begin
        if (dv_done) begin
          var_d = dv_res;
          state_d = S_ORD;
        end
      end
      S_ORD: begin
        cf_raddr = k_q[CW-1:0];
        state_d = S_OWR;
      end
      S_OWR: begin
        // hold the read address and wait until the output register frees up
        cf_raddr = k_q[CW-1:0];
        if (out_free) begin
          ov_d = 1'b1;
          oc_d = (ord_q == '0) ? 32'sd0 : cf_rd;
          oi_d = 5'(k_q);
          oo_d = 6'(ord_q);
          ovar_d = var_q;
          oe_d = err_q;
          ol_d = (ord_q == '0) || (k_q == ord_q - LW'(1));
          if (ol_d) begin
            state_d = S_LOAD;
          end else begin
            k_d = k_q + LW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      om_q    <= LW'(1);
      l_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      ord_q   <= '0;
      err_q   <= 1'b0;
      ov_q    <= 1'b0;
      v_q     <= '0;
      cross_q <= '0;
      psum_q  <= '0;
      rvar_q  <= '0;
    end else begin
      state_q <= state_d;
      om_q    <= om_d;
      l_q     <= l_d;
      j_q     <= j_d;
      k_q     <= k_d;
      ord_q   <= ord_d;
      err_q   <= err_d;
      ov_q    <= ov_d;
      v_q     <= v_d;
      cross_q <= cross_d;
      psum_q  <= psum_d;
      rvar_q  <= rvar_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ac0_q  <= ac0_d;
    r1_q   <= r1_d;
    c_q    <= c_d;
    ak_q   <= ak_d;
    hold_q <= hold_d;
    pk_q   <= pk_d;
    t_q    <= t_d;
    var_q  <= var_d;
    sumd_q <= sumd_d;
    sumq_q <= sumq_d;
    oc_q   <= oc_d;
    oi_q   <= oi_d;
    oo_q   <= oo_d;
    ovar_q <= ovar_d;
    oe_q   <= oe_d;
    ol_q   <= ol_d;
  end

  assign out_valid_o      = ov_q;
  assign coef_value_o     = oc_q;
  assign coef_index_o     = oi_q;
  assign order_found_o    = oo_q;
  assign noise_variance_o = ovar_q;
  assign scale_error_o    = oe_q;
  assign last_result_o    = ol_q;

endmodule

### sim/ldar_checker.sv
`timescale 1ns / 1ps

module ldar_checker import ldar_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [5:0]         lag_index_i,
  input  logic signed [31:0] r_value_i,
  input  logic signed [31:0] g_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] coef_value_i,
  input  logic [4:0]         coef_index_i,
  input  logic [5:0]         order_found_i,
  input  logic signed [31:0] noise_variance_i,
  input  logic               scale_error_i,
  input  logic               last_result_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o
);

  localparam longint QOne    = 64'sd16777216;
  localparam longint QHalf   = 64'sd8388608;
  localparam longint ValMax  = 64'sd2147483647;
  localparam longint ValMin  = -64'sd2147483648;
  localparam int     OrdCap  = 32;

  typedef struct {
    logic signed [31:0] coef;
    logic [4:0]         idx;
    logic [5:0]         ord;
    logic signed [31:0] noise;
    logic               err;
    logic               last;
  } ar_result_t;

  ar_result_t fit_q[$];

  logic [5:0] order_reg;
  longint     thr_reg;
  longint     n_reg;

  longint lag_r[0:OrdCap];
  longint lag_g[0:OrdCap];
  longint pwork[0:OrdCap-1];
  longint coef_acc[0:OrdCap-1];
  longint err_v, cross_d, psum_q, var_run;

  function automatic longint clip(input longint x);
    if (x > ValMax) return ValMax;
    if (x < ValMin) return ValMin;
    return x;
  endfunction

  // round half up while dropping 24 fraction bits
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + QHalf) >>> 24;
  endfunction

  function automatic longint qdiv(input longint num, input longint den);
    if (den == 0) return (num >= 0) ? ValMax : ValMin;
    return clip(num / den);
  endfunction

  function automatic longint mag(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Levinson-Durbin recursion with early stop; returns the accepted order
  function int fit_order(input int om);
    longint c, ak, hold, dsum, qsum, rv;
    int l, j, i, h1, h2, k;
    err_v = lag_r[0];
    cross_d = lag_r[1];
    pwork[0] = QOne;
    c = qdiv(lag_g[1] * QOne, err_v);
    if (mag(c) <= thr_reg) return 0;
    coef_acc[0] = c;
    psum_q = clip(qmul(c, lag_r[1]));
    var_run = clip(qmul(clip(QOne - qmul(c, c)), lag_r[0]));
    if (om == 1) return 1;
    for (l = 2; l <= om; l++) begin
      ak = qdiv(-cross_d * QOne, err_v);
      pwork[l-1] = ak;
      if (l > 2) begin
        h1 = (l - 2) / 2;
        h2 = h1 + 1;
        for (j = 2; j <= h2; j++) begin
          k = l - j + 1;
          hold = pwork[j-1];
          pwork[j-1] = clip(hold + qmul(ak, pwork[k-1]));
          pwork[k-1] = clip(pwork[k-1] + qmul(ak, hold));
        end
        // odd middle term updates in place
        if (2 * h1 != l - 2) pwork[h2] = clip(qmul(pwork[h2], clip(QOne + ak)));
      end
      err_v = clip(err_v + qmul(ak, cross_d));
      c = qdiv((lag_g[l] - psum_q) * QOne, err_v);
      if (mag(c) <= thr_reg) return l - 1;
      for (j = 1; j <= l - 1; j++)
        coef_acc[j-1] = clip(coef_acc[j-1] + qmul(c, pwork[l-j]));
      coef_acc[l-1] = c;
      var_run = clip(qmul(var_run, clip(QOne - qmul(c, c))));
      if (l == om) return om;
      dsum = 0;
      qsum = 0;
      for (i = 1; i <= l; i++) begin
        rv = lag_r[l-i+1];
        dsum += qmul(pwork[i-1], rv);
        qsum += qmul(coef_acc[i-1], rv);
      end
      cross_d = clip(dsum);
      psum_q = clip(qsum);
    end
    return om;
  endfunction

  function automatic int field_diff(input string name, input longint e, input longint a);
    if (e == a) return 0;
    $error("%s mismatch: expected %0d, got %0d", name, e, a);
    return 1;
  endfunction

  task automatic predict_fit(input int lag);
    int om, ord, cnt;
    longint noise, need;
    ar_result_t e;
    om = (order_reg == 0) ? 1 : ((order_reg > OrdCap) ? OrdCap : order_reg);
    if (lag != om) return;
    ord = fit_order(om);
    noise = (ord > 0) ? var_run : lag_r[0];
    need = ord + 1;
    e.err = 1'b0;
    if (n_reg <= need) begin
      e.err = 1'b1;
      noise = 0;
    end else begin
      noise = clip(noise * n_reg / (n_reg - need));
    end
    cnt = (ord > 0) ? ord : 1;
    for (int k = 0; k < cnt; k++) begin
      e.coef = (ord > 0) ? coef_acc[k][31:0] : '0;
      e.idx = k[4:0];
      e.ord = ord[5:0];
      e.noise = noise[31:0];
      e.last = (k == cnt - 1);
      fit_q.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ar_result_t e;
    int bad;
    if (!rst_ni) begin
      order_reg <= 6'd1;
      thr_reg <= 167772;
      n_reg <= 1000;
      fit_q.delete();
      fail_count_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ORDER_MAX: order_reg <= cfg_data_i[5:0];
          CFG_THRESHOLD: thr_reg <= longint'(cfg_data_i[24:0]);
          CFG_SAMPLES:   n_reg <= longint'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i && lag_index_i <= OrdCap) begin
        lag_r[lag_index_i] = longint'(r_value_i);
        lag_g[lag_index_i] = longint'(g_value_i);
        predict_fit(lag_index_i);
      end
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (fit_q.size() == 0) begin
          $error("unexpected result: coef_index %0d order %0d", coef_index_i, order_found_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = fit_q.pop_front();
          bad = field_diff("coef_value", e.coef, coef_value_i)
              + field_diff("coef_index", e.idx, coef_index_i)
              + field_diff("order_found", e.ord, order_found_i)
              + field_diff("noise_variance", e.noise, noise_variance_i)
              + field_diff("scale_error", e.err, scale_error_i)
              + field_diff("last_result", e.last, last_result_i);
          if (bad != 0) fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

  assign pending_o = fit_q.size();

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb import ldar_pkg::*; ();

  localparam int ItemTarget = 500;
  localparam int CycleLimit = 4000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [5:0]         lag_index = '0;
  logic signed [31:0] r_value = '0;
  logic signed [31:0] g_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] coef_value;
  logic [4:0]         coef_index;
  logic [5:0]         order_found;
  logic signed [31:0] noise_variance;
  logic               scale_error;
  logic               last_result;

  int fail_count, pending, results;
  int cycles = 0;
  int sent = 0;
  int settings = 0;
  int hold_len = 0;    // one-shot long output stall, picked up by the receiver
  bit no_idle = 1'b0;  // both sides run back to back while set
  bit written[0:32];   // lags loaded since reset
  int eff_order = 1;

  always #4 clk_i = ~clk_i;

  levinson_durbin_ar_fit DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .lag_index_i(lag_index), .r_value_i(r_value), .g_value_i(g_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .coef_value_o(coef_value), .coef_index_o(coef_index),
    .order_found_o(order_found), .noise_variance_o(noise_variance),
    .scale_error_o(scale_error), .last_result_o(last_result)
  );

  ldar_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .lag_index_i(lag_index), .r_value_i(r_value), .g_value_i(g_value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .coef_value_i(coef_value), .coef_index_i(coef_index),
    .order_found_i(order_found), .noise_variance_i(noise_variance),
    .scale_error_i(scale_error), .last_result_i(last_result),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results)
  );

  // Guard against a hung block: end the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result receiver: stall for a random spell before each result (none while no_idle is set), or
  // the long hold-off once when requested, so the block backs up.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Offer one lag request; entered and left at a falling edge.
  task automatic put_lag(input int lag, input logic [31:0] r, input logic [31:0] g);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 3);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    lag_index <= lag[5:0];
    r_value <= r;
    g_value <= g;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    if (lag <= 32) written[lag] = 1'b1;
    sent++;
  endtask

  task automatic write_reg(input ldar_cfg_e idx, input logic [31:0] d);
    in_valid <= 1'b0;
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every outstanding result, then let the block return to idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (64) @(negedge clk_i);
  endtask

  task automatic configure(input int om, input logic [31:0] thr, input logic [31:0] n);
    settle();
    write_reg(CFG_ORDER_MAX, om);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_SAMPLES, n);
    eff_order = (om[5:0] == 0) ? 1 : ((om[5:0] > 32) ? 32 : om[5:0]);
    settings++;
  endtask

  // Random value: full range now and then, otherwise scaled down.
  function automatic logic [31:0] pick_val();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  // One well-formed lag set, mostly with a positive lag 0 so the fit goes deep.
  task automatic send_set();
    for (int l = 0; l <= eff_order; l++) begin
      if (l == 0 && $urandom_range(0, 7) != 0)
        put_lag(0, $urandom_range(32'h0001_0000, 32'h0100_0000), pick_val());
      else
        put_lag(l, pick_val(), pick_val());
    end
  endtask

  // Stray request: ignored lag, or a reload that may also restart the fit.
  task automatic send_noise();
    int lag;
    bit ok;
    lag = $urandom_range(0, 63);
    ok = 1'b1;
    for (int l = 0; l <= eff_order; l++) ok &= written[l];
    if (lag == eff_order && !ok) lag = 33 + $urandom_range(0, 30);
    put_lag(lag, $urandom, $urandom);
  endtask

  initial begin
    int om_tab[12] = '{1, 2, 3, 4, 6, 8, 32, 63, 0, 5, 12, 2};
    logic [31:0] thr_tab[4] = '{32'd0, 32'd16777216, 32'd167772, 32'd1000000};
    logic [31:0] n_tab[5] = '{32'd1, 32'hffff_ffff, 32'd1000, 32'd3, 32'd40};
    int ph, sets;
    logic [31:0] thr, n;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, ignored lags, zero lag-0 divisor, normal fit.
    put_lag(0, 32'h7fff_ffff, 32'h8000_0000);
    put_lag(1, 32'h8000_0000, 32'h7fff_ffff);
    put_lag(40, 32'h1234_5678, 32'h8765_4321);
    put_lag(63, 32'hffff_ffff, 32'h0);
    put_lag(0, 32'h0, 32'h0001_0000);
    put_lag(1, 32'h0000_8000, 32'h0000_4000);
    put_lag(0, 32'h0001_0000, 32'h0000_8000);
    put_lag(1, 32'h0000_4000, 32'h0000_2000);
    put_lag(0, 32'h0001_0000, 32'hffff_0000);
    put_lag(1, 32'hffff_c000, 32'h8000_0000);
    // Order zero with a bad scale; order register zero acts as one.
    configure(0, 32'd16777216, 32'd1);
    put_lag(0, 32'h0001_0000, 32'h0);
    put_lag(1, 32'h0000_8000, 32'h0000_0100);
    configure(1, 32'd0, 32'd2);
    put_lag(0, 32'h0001_0000, 32'h0);
    put_lag(1, 32'h0000_8000, 32'h0000_8000);

    // Random phases: sweep the order, threshold and sample count.
    ph = 0;
    while (sent < ItemTarget) begin
      thr = (ph < 8) ? thr_tab[ph % 4] : $urandom_range(0, 16777216);
      n = (ph < 10) ? n_tab[ph % 5] : $urandom_range(1, 200);
      configure((ph < 12) ? om_tab[ph] : $urandom_range(1, 10), thr, n);
      no_idle = (ph % 4 == 3);
      if (ph == 2) hold_len = 400;
      sets = (eff_order >= 16) ? 1 : $urandom_range(3, 8);
      for (int s = 0; s < sets; s++) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        send_set();
      end
      ph++;
    end
    no_idle = 1'b0;

    settle();
    repeat (200) @(negedge clk_i);
    $display("covered %0d lag requests and %0d checked coefficients", sent, results);
    $display("over %0d register settings, %0d failing results", settings, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
